// ----- sv/spatial_hash_table_probe_assert.svh -----
// Assertion macros for the spatial hash table probe.
`ifndef SPATIAL_HASH_TABLE_PROBE_ASSERT_SVH
`define SPATIAL_HASH_TABLE_PROBE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SHTP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SHTP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/shtp_pkg.sv -----
// Package: types, codes and constants of the spatial hash table probe.
`timescale 1ns / 1ps
package shtp_pkg;

    localparam int TABLE_SLOTS_DEF = 1024;
    localparam int HANDLE_BITS_DEF = 32;
    localparam int QUEUE_DEPTH     = 2;

    localparam int KEY_W      = 16;
    localparam int HANDLE_W   = 32;
    localparam int SLOT_OUT_W = 10;
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 48;

    localparam logic [31:0] HASH_PRIME_X = 32'd73856093;
    localparam logic [31:0] HASH_PRIME_Y = 32'd19349663;

    typedef enum logic [0:0] {
        FUNC_FIND   = 1'b0,
        FUNC_INSERT = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_FULL      = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_CHECK,
        S_FINISH
    } state_t;

    typedef struct packed {
        func_t               func;
        logic [KEY_W-1:0]    key_x;
        logic [KEY_W-1:0]    key_y;
        logic [HANDLE_W-1:0] value_handle;
    } job_t;

    typedef struct packed {
        logic [3:0]            pad;
        logic [SLOT_OUT_W-1:0] slot_index;
        logic [HANDLE_W-1:0]   found_handle;
        status_t               status;
    } result_t;

    localparam int JOB_W = $bits(job_t);

endpackage

// ----- sv/shtp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module shtp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/shtp_queue.sv -----
// Small FIFO between the front end and the probe engine.
`timescale 1ns / 1ps
module shtp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = shtp_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             ready,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign ready   = (count_reg != CNT_W'(DEPTH));
    assign valid   = (count_reg != '0);
    assign do_push = push && ready;
    assign do_pop  = pop && valid;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (do_push && !do_pop)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ----- sv/shtp_front.sv -----
// Front end: accepts requests, hashes the key to its home slot, queues the job.
`timescale 1ns / 1ps
module shtp_front #(
    parameter int TABLE_SLOTS = shtp_pkg::TABLE_SLOTS_DEF
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             init_done,
    input  logic                                             s_tvalid,
    output logic                                             s_tready,
    input  logic [shtp_pkg::S_TDATA_W-1:0]                   s_tdata,  // key_x, key_y, value_handle
    input  logic [0:0]                                       s_tuser,  // func
    output logic                                             q_push,
    output logic [shtp_pkg::JOB_W+$clog2(TABLE_SLOTS)-1:0]   q_wdata,
    input  logic                                             q_ready
);

    localparam int SLOT_BITS = $clog2(TABLE_SLOTS);

    shtp_pkg::job_t   job_in;
    shtp_pkg::job_t   job_reg;
    logic             valid_reg, valid_next;
    logic [31:0]      kx_ext, ky_ext;
    logic [31:0]      prod_x, prod_y;
    logic [31:0]      prod_x_reg, prod_y_reg;
    logic [31:0]      hash;
    logic             accept;

    assign job_in.func         = shtp_pkg::func_t'(s_tuser[0]);
    assign job_in.key_x        = s_tdata[15:0];
    assign job_in.key_y        = s_tdata[31:16];
    assign job_in.value_handle = s_tdata[63:32];

    assign kx_ext = {{16{job_in.key_x[15]}}, job_in.key_x};
    assign ky_ext = {{16{job_in.key_y[15]}}, job_in.key_y};
    assign prod_x = kx_ext * shtp_pkg::HASH_PRIME_X;
    assign prod_y = ky_ext * shtp_pkg::HASH_PRIME_Y;

    assign s_tready = init_done && (!valid_reg || q_ready);
    assign accept   = s_tvalid && s_tready;
    assign q_push   = valid_reg && q_ready;
    assign hash     = prod_x_reg ^ prod_y_reg;
    assign q_wdata  = {job_reg, hash[SLOT_BITS-1:0]};

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (q_push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_reg    <= job_in;
            prod_x_reg <= prod_x;
            prod_y_reg <= prod_y;
        end
    end

endmodule

// ----- sv/shtp_back.sv -----
// Probe engine: clears the table after reset, walks slots linearly, drives results.
`timescale 1ns / 1ps
`include "spatial_hash_table_probe_assert.svh"
module shtp_back #(
    parameter int TABLE_SLOTS = shtp_pkg::TABLE_SLOTS_DEF,
    parameter int HANDLE_BITS = shtp_pkg::HANDLE_BITS_DEF
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    output logic                                             init_done,
    input  logic                                             q_valid,
    input  logic [shtp_pkg::JOB_W+$clog2(TABLE_SLOTS)-1:0]   q_rdata,
    output logic                                             q_pop,
    output logic                                             m_tvalid,
    input  logic                                             m_tready,
    output logic [shtp_pkg::M_TDATA_W-1:0]                   m_tdata   // status, found_handle, slot_index
);

    localparam int SLOT_BITS = $clog2(TABLE_SLOTS);
    localparam int KW        = shtp_pkg::KEY_W;
    localparam int ENTRY_W   = 1 + 2 * KW + HANDLE_BITS;

    shtp_pkg::state_t  state_reg, state_next;
    shtp_pkg::job_t    job_reg, q_job;
    shtp_pkg::result_t res_reg, res_next, out_reg;
    logic [SLOT_BITS-1:0] clr_reg, clr_next;
    logic [SLOT_BITS-1:0] idx_reg, idx_next, idx_inc;
    logic [SLOT_BITS-1:0] home_reg, q_home;
    logic                 m_tvalid_reg, m_tvalid_next;

    logic                 ram_we;
    logic [SLOT_BITS-1:0] ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0]   ram_wdata, ram_rdata;

    logic                   e_valid;
    logic [KW-1:0]          e_kx, e_ky;
    logic [HANDLE_BITS-1:0] e_handle;
    logic [63:0]            h_in_ext, h_out_ext;
    logic [31:0]            slot_ext;
    logic                   is_insert, match, wrap, probe_done, clr_last, out_free;
    logic                   res_load, out_load;

    assign q_job  = shtp_pkg::job_t'(q_rdata[shtp_pkg::JOB_W+SLOT_BITS-1:SLOT_BITS]);
    assign q_home = q_rdata[SLOT_BITS-1:0];

    assign e_valid  = ram_rdata[ENTRY_W-1];
    assign e_kx     = ram_rdata[ENTRY_W-2 -: KW];
    assign e_ky     = ram_rdata[HANDLE_BITS+KW-1 -: KW];
    assign e_handle = ram_rdata[HANDLE_BITS-1:0];

    assign h_in_ext  = 64'(job_reg.value_handle);
    assign h_out_ext = 64'(e_handle);
    assign slot_ext  = 32'(idx_reg);

    assign is_insert  = (job_reg.func == shtp_pkg::FUNC_INSERT);
    assign match      = (e_kx == job_reg.key_x) && (e_ky == job_reg.key_y);
    assign idx_inc    = SLOT_BITS'(idx_reg + 1'b1);
    assign wrap       = (idx_inc == home_reg);
    assign probe_done = !e_valid || wrap || (!is_insert && match);
    assign clr_last   = (clr_reg == SLOT_BITS'(TABLE_SLOTS - 1));
    assign out_free   = !m_tvalid_reg || m_tready;
    assign init_done  = (state_reg != shtp_pkg::S_INIT);

    shtp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            shtp_pkg::S_INIT:
            begin
                if (clr_last)
                begin
                    state_next = shtp_pkg::S_IDLE;
                end
            end
            shtp_pkg::S_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = shtp_pkg::S_CHECK;
                end
            end
            shtp_pkg::S_CHECK:
            begin
                if (probe_done)
                begin
                    state_next = shtp_pkg::S_FINISH;
                end
            end
            shtp_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = shtp_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = shtp_pkg::S_INIT;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = '0;
        ram_raddr = idx_reg;
        q_pop     = 1'b0;
        res_load  = 1'b0;
        out_load  = 1'b0;
        clr_next  = clr_reg;
        idx_next  = idx_reg;
        res_next  = '0;
        case (state_reg)
            shtp_pkg::S_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = SLOT_BITS'(clr_reg + 1'b1);
            end
            shtp_pkg::S_IDLE:
            begin
                ram_raddr = q_home;
                q_pop     = q_valid;
                idx_next  = q_home;
            end
            shtp_pkg::S_CHECK:
            begin
                ram_raddr = idx_inc;
                res_load  = probe_done;
                if (!probe_done)
                begin
                    idx_next = idx_inc;
                end
                if (is_insert)
                begin
                    if (!e_valid)
                    begin
                        ram_we          = 1'b1;
                        ram_wdata       = {1'b1, job_reg.key_x, job_reg.key_y,
                                           h_in_ext[HANDLE_BITS-1:0]};
                        res_next.status = shtp_pkg::STATUS_OK;
                        res_next.slot_index = slot_ext[shtp_pkg::SLOT_OUT_W-1:0];
                    end
                    else
                    begin
                        res_next.status = shtp_pkg::STATUS_FULL;
                    end
                end
                else if (e_valid && match)
                begin
                    res_next.status       = shtp_pkg::STATUS_OK;
                    res_next.found_handle = h_out_ext[shtp_pkg::HANDLE_W-1:0];
                    res_next.slot_index   = slot_ext[shtp_pkg::SLOT_OUT_W-1:0];
                end
                else
                begin
                    res_next.status = shtp_pkg::STATUS_NOT_FOUND;
                end
            end
            shtp_pkg::S_FINISH:
            begin
                out_load = out_free;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= shtp_pkg::S_INIT;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (q_pop)
        begin
            job_reg  <= q_job;
            home_reg <= q_home;
        end
        if (res_load)
        begin
            res_reg <= res_next;
        end
        if (out_load)
        begin
            out_reg <= res_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

    `SHTP_ASSERT_NOW(a_we_state, ram_we, (state_reg == shtp_pkg::S_INIT || state_reg == shtp_pkg::S_CHECK), "RAM write outside clear or probe")
    `SHTP_ASSERT_NOW(a_pop_idle, q_pop, (state_reg == shtp_pkg::S_IDLE && init_done), "queue pop outside idle")
    `SHTP_ASSERT_NOW(a_full_insert, (res_load && res_next.status == shtp_pkg::STATUS_FULL), is_insert, "full reported for a find")
    `SHTP_ASSERT_NOW(a_miss_zero, (m_tvalid_reg && out_reg.status != shtp_pkg::STATUS_OK), (out_reg.slot_index == '0 && out_reg.found_handle == '0), "miss result carries data")
    `SHTP_ASSERT_NEXT(a_out_load, out_load, m_tvalid_reg, "result lost on load")

endmodule

// ----- sv/spatial_hash_table_probe.sv -----
// Top level: open-addressing spatial hash table with linear probing.
// A request passes the front stage, the queue and the probe engine, which probes one or more slots.
// The table RAM read port reads one slot a cycle while a probe walks the table.
// A front stage and a two-entry queue keep accepting while the probe engine works.
// Reset: asynchronous, active low; afterwards a clearing pass writes every slot
// invalid, and no input is accepted until it completes.
`timescale 1ns / 1ps
module spatial_hash_table_probe #(
    parameter int TABLE_SLOTS = shtp_pkg::TABLE_SLOTS_DEF,
    parameter int HANDLE_BITS = shtp_pkg::HANDLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [shtp_pkg::S_TDATA_W-1:0] s_tdata,  // key_x[15:0], key_y[31:16], value_handle[63:32]
    input  logic [0:0]                    s_tuser,  // func[0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [shtp_pkg::M_TDATA_W-1:0] m_tdata   // status[1:0], found_handle[33:2], slot_index[43:34]
);

    localparam int QW = shtp_pkg::JOB_W + $clog2(TABLE_SLOTS);

    logic          init_done;
    logic          q_push, q_ready, q_pop, q_valid;
    logic [QW-1:0] q_wdata, q_rdata;

    shtp_front #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .init_done (init_done),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_push    (q_push),
        .q_wdata   (q_wdata),
        .q_ready   (q_ready)
    );

    shtp_queue #(
        .WIDTH (QW),
        .DEPTH (shtp_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .ready (q_ready),
        .pop   (q_pop),
        .rdata (q_rdata),
        .valid (q_valid)
    );

    shtp_back #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .init_done (init_done),
        .q_valid   (q_valid),
        .q_rdata   (q_rdata),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ----- sim/tb.sv -----
// Testbench for spatial_hash_table_probe: streamed finds and inserts scored against a table model.
`timescale 1ns / 1ps
module tb;
    import shtp_pkg::*;

    localparam int SLOTS = TABLE_SLOTS_DEF;
    localparam int MAX_WAIT = 11;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [0:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // table model
    bit occupied [SLOTS];
    logic [KEY_W-1:0] stored_x [SLOTS];
    logic [KEY_W-1:0] stored_y [SLOTS];
    logic [HANDLE_W-1:0] stored_handle [SLOTS];

    job_t jobs_to_send[$];
    result_t expected_results[$];
    logic [KEY_W-1:0] known_x[$];
    logic [KEY_W-1:0] known_y[$];
    int inserts_queued = 0;
    int mismatch_count = 0;
    longint cycle_count = 0;
    longint cycle_limit = 64'd10_000_000;

    job_t next_job;
    int send_wait = 0;
    bit send_quiet = 0;
    int recv_wait = 0;
    bit recv_quiet = 0;
    result_t got;
    result_t want;

    spatial_hash_table_probe uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    function automatic int home_slot(logic [KEY_W-1:0] kx, logic [KEY_W-1:0] ky);
        logic [31:0] hx;
        logic [31:0] hy;
        hx = {{16{kx[KEY_W-1]}}, kx} * HASH_PRIME_X;
        hy = {{16{ky[KEY_W-1]}}, ky} * HASH_PRIME_Y;
        return int'((hx ^ hy) & (SLOTS - 1));
    endfunction

    // walks the table model, applies an insert and returns the expected result
    function automatic result_t probe_table(func_t op, logic [KEY_W-1:0] kx,
                                            logic [KEY_W-1:0] ky, logic [HANDLE_W-1:0] handle);
        result_t r;
        int start;
        int idx;
        bit done;
        r = '0;
        r.status = (op == FUNC_INSERT) ? STATUS_FULL : STATUS_NOT_FOUND;
        start = home_slot(kx, ky);
        done = 0;
        for (int n = 0; n < SLOTS && !done; n++)
        begin
            idx = (start + n) % SLOTS;
            if (op == FUNC_INSERT)
            begin
                if (!occupied[idx])
                begin
                    occupied[idx] = 1'b1;
                    stored_x[idx] = kx;
                    stored_y[idx] = ky;
                    stored_handle[idx] = handle;
                    r.status = STATUS_OK;
                    r.slot_index = SLOT_OUT_W'(idx);
                    done = 1;
                end
            end
            else if (!occupied[idx])
                done = 1;
            else if (stored_x[idx] == kx && stored_y[idx] == ky)
            begin
                r.status = STATUS_OK;
                r.found_handle = stored_handle[idx];
                r.slot_index = SLOT_OUT_W'(idx);
                done = 1;
            end
        end
        return r;
    endfunction

    task automatic add_job(func_t op, logic [KEY_W-1:0] kx, logic [KEY_W-1:0] ky,
                           logic [HANDLE_W-1:0] handle);
        job_t j;
        j.func = op;
        j.key_x = kx;
        j.key_y = ky;
        j.value_handle = handle;
        jobs_to_send.push_back(j);
        if (op == FUNC_INSERT)
        begin
            inserts_queued++;
            known_x.push_back(kx);
            known_y.push_back(ky);
        end
    endtask

    task automatic pick_colliding(input int target, output logic [KEY_W-1:0] kx,
                                  output logic [KEY_W-1:0] ky);
        do
        begin
            kx = KEY_W'($urandom);
            ky = KEY_W'($urandom);
        end while (home_slot(kx, ky) != target);
    endtask

    task automatic random_key(output logic [KEY_W-1:0] kx, output logic [KEY_W-1:0] ky);
        if ($urandom_range(0, 4) == 0)
        begin
            kx = KEY_W'($signed($urandom_range(0, 15)) - 8);
            ky = KEY_W'($signed($urandom_range(0, 15)) - 8);
        end
        else
        begin
            kx = KEY_W'($urandom);
            ky = KEY_W'($urandom);
        end
    endtask

    task automatic known_key(output logic [KEY_W-1:0] kx, output logic [KEY_W-1:0] ky);
        int k;
        k = $urandom_range(0, known_x.size() - 1);
        kx = known_x[k];
        ky = known_y[k];
    endtask

    task automatic random_job(int insert_pct);
        logic [KEY_W-1:0] kx;
        logic [KEY_W-1:0] ky;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < insert_pct)
        begin
            if ($urandom_range(0, 9) == 0)
                known_key(kx, ky);
            else
                random_key(kx, ky);
            add_job(FUNC_INSERT, kx, ky, $urandom);
        end
        else
        begin
            if ($urandom_range(0, 1) == 0)
                known_key(kx, ky);
            else
                random_key(kx, ky);
            add_job(FUNC_FIND, kx, ky, $urandom);
        end
    endtask

    task automatic build_stimulus();
        logic [KEY_W-1:0] ax, ay, bx, by, cx, cy, dx, dy, ex, ey;
        // directed: empty table, key extremes, collisions, duplicates, wrap at the table end
        add_job(FUNC_FIND, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
        add_job(FUNC_INSERT, 16'h8000, 16'h7FFF, 32'hFFFF_FFFF);
        add_job(FUNC_INSERT, 16'h7FFF, 16'h8000, 32'h0000_0000);
        add_job(FUNC_FIND, 16'h8000, 16'h7FFF, 32'h0000_0000);
        add_job(FUNC_FIND, 16'h7FFF, 16'h8000, 32'hFFFF_FFFF);
        ax = 16'h0000;
        ay = 16'h0000;
        pick_colliding(0, bx, by);
        pick_colliding(0, cx, cy);
        pick_colliding(SLOTS - 1, dx, dy);
        pick_colliding(SLOTS - 1, ex, ey);
        add_job(FUNC_INSERT, ax, ay, 32'h1111_1111);
        add_job(FUNC_INSERT, bx, by, 32'h2222_2222);
        add_job(FUNC_FIND, bx, by, 32'h0);
        add_job(FUNC_INSERT, ax, ay, 32'h3333_3333);
        add_job(FUNC_FIND, ax, ay, 32'h0);
        add_job(FUNC_INSERT, dx, dy, 32'hA5A5_A5A5);
        add_job(FUNC_INSERT, dx, dy, 32'h5A5A_5A5A);
        add_job(FUNC_FIND, dx, dy, 32'h0);
        add_job(FUNC_FIND, ex, ey, 32'h0);
        add_job(FUNC_FIND, cx, cy, 32'h0);
        add_job(FUNC_INSERT, 16'hFFFF, 16'hFFFF, 32'h8000_0001);
        add_job(FUNC_FIND, 16'hFFFF, 16'hFFFF, 32'h0);
        add_job(FUNC_FIND, 16'h0001, 16'h0001, 32'h0);
        // random mix at light and moderate load
        repeat (700)
            random_job(45);
        // fill the table completely
        while (inserts_queued < SLOTS)
            random_job(85);
        // full table: inserts fail, misses wrap all the way round
        repeat (40)
            random_job(35);
        cycle_limit = 3 * (SLOTS + longint'(jobs_to_send.size()) * (SLOTS + 6 + 2 * MAX_WAIT))
                      + 4000;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            send_wait = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_results.push_back(probe_table(func_t'(s_tuser[0]), s_tdata[15:0],
                                                       s_tdata[31:16], s_tdata[63:32]));
            if (!s_tvalid || s_tready)
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    s_tvalid <= 1'b0;
                end
                else if (jobs_to_send.size() > 0)
                begin
                    next_job = jobs_to_send.pop_front();
                    s_tdata <= {next_job.value_handle, next_job.key_y, next_job.key_x};
                    s_tuser <= next_job.func;
                    s_tvalid <= 1'b1;
                    if ($urandom_range(0, 39) == 0)
                        send_quiet = !send_quiet;
                    send_wait = send_quiet ? 0 : $urandom_range(0, MAX_WAIT);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_wait = 0;
        end
        else if (m_tvalid && m_tready)
        begin
            got = result_t'(m_tdata);
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected transfer: expected none, actual %h", $time, m_tdata);
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.status != want.status)
                begin
                    $display("%0t: status: expected %0d, actual %0d", $time, want.status,
                             got.status);
                    mismatch_count++;
                end
                if (got.found_handle != want.found_handle)
                begin
                    $display("%0t: found_handle: expected %h, actual %h", $time,
                             want.found_handle, got.found_handle);
                    mismatch_count++;
                end
                if (got.slot_index != want.slot_index)
                begin
                    $display("%0t: slot_index: expected %0d, actual %0d", $time,
                             want.slot_index, got.slot_index);
                    mismatch_count++;
                end
            end
            if ($urandom_range(0, 39) == 0)
                recv_quiet = !recv_quiet;
            recv_wait = recv_quiet ? 0 : $urandom_range(0, MAX_WAIT);
            if (recv_wait > 0)
                m_tready <= 1'b0;
        end
        else if (!m_tready)
        begin
            if (recv_wait > 0)
                recv_wait--;
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > cycle_limit)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        build_stimulus();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        while (jobs_to_send.size() != 0 || s_tvalid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SLOTS + 64) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/shtp_pkg.sv
sv/shtp_ram.sv
sv/shtp_queue.sv
sv/shtp_front.sv
sv/shtp_back.sv
sv/spatial_hash_table_probe.sv
sim/tb.sv
